// ===== hw/rtl/cpd_pkg.sv =====
// Package: types, constants and the id length table of the command packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

  localparam logic [7:0] TAIL_MARK  = 8'hED;
  localparam logic [7:0] BT_SECOND  = 8'hBF;
  localparam logic [7:0] ACK_A      = 8'hAA;
  localparam logic [7:0] ACK_B      = 8'hEE;
  localparam logic [7:0] ID_VARLEN  = 8'hF1;
  localparam logic [7:0] ID_BT      = 8'hFB;
  localparam logic [7:0] BT_NO_LEN  = 8'h01;
  localparam logic [8:0] VARLEN_ADD = 9'd5;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FORMAT = 2'd1,
    ST_CHECK  = 2'd2
  } status_e;

  typedef struct packed {
    logic       in_packet;
    logic [7:0] head_id;
    logic [8:0] byte_index;
    logic [8:0] target_length;
    logic       length_known;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] running_sum;
    logic [7:0] received_sum;
  } cpd_state_t;

  typedef struct packed {
    logic [7:0] command_id;
    logic [8:0] packet_length;
    status_e    status;
  } cpd_result_t;

  // Fixed length per id; zero marks an unknown id.
  function automatic logic [8:0] table_length(input logic [7:0] id);
    logic [8:0] len;
    case (id)
      8'hFD, 8'hFC, 8'hFB, 8'hFA:                 len = 9'd10;
      8'hF9, 8'hF8, 8'hF7, 8'hF6, 8'hF4, 8'hF3:   len = 9'd4;
      8'hF5:                                      len = 9'd15;
      8'hF2:                                      len = 9'd5;
      8'hEF:                                      len = 9'd8;
      8'hF1:                                      len = 9'd1;
      default:                                    len = 9'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpd_if.sv =====
// Valid/ready channel interfaces for received bytes and packet results.
`timescale 1ns / 1ps
`default_nettype none

interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_id;
  logic [8:0] packet_length;
  logic [1:0] status;

  modport source (output valid, output command_id, output packet_length, output status,
                  input ready);
  modport sink (input valid, input command_id, input packet_length, input status,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpd_step.sv =====
// Per-byte framing logic: next parser state and the result of a finished packet.
`timescale 1ns / 1ps
`default_nettype none

module cpd_step
  import cpd_pkg::*;
(
  input  cpd_state_t  state_i,
  input  logic [7:0]  rx_byte_i,
  output cpd_state_t  state_o,
  output logic        done_o,
  output cpd_result_t result_o
);

  logic [8:0] tbl_len;
  logic       tbl_var;
  logic [8:0] tgt;
  logic       known;
  logic [8:0] count;
  logic [7:0] swapped;
  logic [7:0] chk;
  status_e    status;

  assign tbl_len = table_length(rx_byte_i);
  assign tbl_var = (rx_byte_i == ID_VARLEN);
  assign count   = state_i.byte_index + 9'd1;
  assign swapped = {state_i.second_byte[3:0], state_i.second_byte[7:4]};
  assign chk     = state_i.running_sum - state_i.received_sum;

  always_comb begin
    state_o  = state_i;
    done_o   = 1'b0;
    tgt      = state_i.target_length;
    known    = state_i.length_known;
    status   = ST_FORMAT;

    if (!state_i.in_packet) begin
      if (tbl_len != 9'd0) begin
        state_o.in_packet     = 1'b1;
        state_o.head_id       = rx_byte_i;
        state_o.byte_index    = 9'd1;
        state_o.target_length = tbl_var ? 9'd0 : tbl_len;
        state_o.length_known  = !tbl_var;
        state_o.second_byte   = '0;
        state_o.third_byte    = '0;
        state_o.running_sum   = '0;
        state_o.received_sum  = '0;
      end
    end else begin
      if (state_i.byte_index == 9'd1) begin
        state_o.second_byte = rx_byte_i;
      end
      if (state_i.byte_index == 9'd2) begin
        state_o.third_byte = rx_byte_i;
        // Variable-length ids take their length from the third byte
        if (state_i.head_id == ID_VARLEN) begin
          tgt   = {1'b0, rx_byte_i} + VARLEN_ADD;
          known = 1'b1;
        end else if (state_i.head_id == ID_BT && state_i.second_byte == BT_SECOND &&
                     rx_byte_i != BT_NO_LEN) begin
          tgt   = {1'b0, rx_byte_i} + 9'd1;
          known = 1'b1;
        end
      end

      if (known && count >= tgt) begin
        done_o = 1'b1;
        if (count < 9'd4 || swapped != state_i.head_id) begin
          status = ST_FORMAT;
        end else if (count == 9'd4) begin
          status = ((state_i.third_byte == ACK_A || state_i.third_byte == ACK_B) &&
                    rx_byte_i == TAIL_MARK) ? ST_ACCEPT : ST_FORMAT;
        end else begin
          status = (chk == state_i.received_sum && rx_byte_i == TAIL_MARK) ?
                   ST_ACCEPT : ST_CHECK;
        end
        state_o.in_packet     = 1'b0;
        state_o.byte_index    = '0;
        state_o.target_length = '0;
        state_o.length_known  = 1'b0;
        state_o.running_sum   = '0;
        state_o.received_sum  = '0;
      end else begin
        if (state_i.byte_index >= 9'd2) begin
          state_o.running_sum = state_i.running_sum + rx_byte_i;
        end
        state_o.received_sum  = rx_byte_i;
        state_o.byte_index    = count;
        state_o.target_length = tgt;
        state_o.length_known  = known;
      end
    end

    result_o.command_id    = state_i.head_id;
    result_o.packet_length = count;
    result_o.status        = status;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/command_packet_deframer.sv =====
// Top level of the command packet deframer: parser state, result register, handshakes.
//
// Takes one received byte per cycle and emits one result (id, length, status) per
// finished packet, in the cycle after the packet's last byte is accepted. Bytes that
// arrive while no packet is open and are not a known command id are dropped silently.
// All per-byte work is a compare, an 8-bit add and a counter step on the parser state,
// so the block sustains one byte per cycle; rx ready falls only while a result sits in
// the output register and the result side is not taking it.
`timescale 1ns / 1ps
`default_nettype none

module command_packet_deframer
  import cpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  cpd_in_if.sink          rx_i,
  cpd_out_if.source       res_o
);

  cpd_state_t  state_q;
  cpd_state_t  state_d;
  logic        done;
  cpd_result_t result_d;
  cpd_result_t result_q;
  logic        out_valid_q;
  logic        accept;

  cpd_step u_step (
    .state_i   (state_q),
    .rx_byte_i (rx_i.rx_byte),
    .state_o   (state_d),
    .done_o    (done),
    .result_o  (result_d)
  );

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept && done) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && done) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.command_id    = result_q.command_id;
  assign res_o.packet_length = result_q.packet_length;
  assign res_o.status        = result_q.status;

endmodule

`default_nettype wire

// ===== hw/rtl/cpd_checker.sv =====
// Port-level assertions for the command packet deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cpd_checker
  import cpd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] command_id_i,
  input logic [8:0] packet_length_i,
  input logic [1:0] status_i
);

  // A held result keeps its payload until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(command_id_i) &&
      $stable(packet_length_i) && $stable(status_i))
    else $error("result changed while stalled");

  // Input is only back-pressured by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> res_valid_i && !res_ready_i)
    else $error("rx ready low without a stalled result");

  // A new result needs a byte accepted in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i))
    else $error("result without an accepted byte");

  // Accepted packets are at least four bytes; no result is longer than 260 bytes; status code is in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (status_i == ST_ACCEPT || status_i == ST_FORMAT ||
      status_i == ST_CHECK) && (status_i != ST_ACCEPT || packet_length_i >= 9'd4) &&
      packet_length_i <= 9'd260)
    else $error("bad result status or length");

endmodule

bind command_packet_deframer cpd_checker u_cpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_valid_i      (rx_i.valid),
  .rx_ready_i      (rx_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .command_id_i    (res_o.command_id),
  .packet_length_i (res_o.packet_length),
  .status_i        (res_o.status)
);

`default_nettype wire

// ===== verif/command_packet_deframer_test.sv =====
// Testbench for the command packet deframer: random byte streams checked against a packet parser.
`timescale 1ns / 1ps

module command_packet_deframer_test;
  import cpd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BYTES = 325;

  logic clk_i = 1'b0;
  logic rst_ni;

  cpd_in_if  rx_bus ();
  cpd_out_if res_bus ();

  command_packet_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .res_o  (res_bus)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0]  bytes_to_send [$];
  cpd_result_t packets_due [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          rx_fire = 1'b0;
  bit          res_fire = 1'b0;
  bit          long_hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  // Parser state mirrored from the block
  logic       p_open = 1'b0;
  logic [7:0] p_head = '0;
  logic [8:0] p_count = '0;
  logic [8:0] p_target = '0;
  logic       p_len_known = 1'b0;
  logic [7:0] p_b1 = '0;
  logic [7:0] p_b2 = '0;
  logic [7:0] p_sum = '0;
  logic [7:0] p_prev = '0;

  function automatic logic [7:0] nibble_swap(input logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  // Fixed length per command id; zero for an unknown id. The variable-length id
  // gets its length from the third byte.
  function automatic logic [8:0] id_length(input logic [7:0] id, output bit varlen);
    varlen = 1'b0;
    case (id)
      8'hFD, 8'hFC, 8'hFB, 8'hFA:               return 9'd10;
      8'hF9, 8'hF8, 8'hF7, 8'hF6, 8'hF4, 8'hF3: return 9'd4;
      8'hF5:                                    return 9'd15;
      8'hF2:                                    return 9'd5;
      8'hEF:                                    return 9'd8;
      ID_VARLEN: begin
        varlen = 1'b1;
        return 9'd1;
      end
      default:                                  return 9'd0;
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(12))
      0:  return 8'hFD;
      1:  return 8'hFC;
      2:  return ID_BT;
      3:  return 8'hFA;
      4:  return 8'hF9;
      5:  return 8'hF8;
      6:  return 8'hF7;
      7:  return 8'hF6;
      8:  return 8'hF4;
      9:  return 8'hF3;
      10: return 8'hF5;
      11: return 8'hF2;
      default: return 8'hEF;
    endcase
  endfunction

  // Feeds one accepted byte to the parser; returns 1 when a packet closes.
  function automatic bit deframe_byte(input logic [7:0] b, output cpd_result_t done);
    logic [8:0] n;
    logic [7:0] chk;
    bit         varlen;
    status_e    st;
    done = '0;
    if (!p_open) begin
      n = id_length(b, varlen);
      if (n == '0) return 1'b0;
      p_open      = 1'b1;
      p_head      = b;
      p_count     = 9'd1;
      p_target    = varlen ? 9'd0 : n;
      p_len_known = !varlen;
      p_b1        = '0;
      p_b2        = '0;
      p_sum       = '0;
      p_prev      = '0;
      return 1'b0;
    end
    if (p_count == 9'd1) p_b1 = b;
    if (p_count == 9'd2) begin
      p_b2 = b;
      if (p_head == ID_VARLEN) begin
        p_target    = {1'b0, b} + VARLEN_ADD;
        p_len_known = 1'b1;
      end else if (p_head == ID_BT && p_b1 == BT_SECOND && b != BT_NO_LEN) begin
        p_target    = {1'b0, b} + 9'd1;
        p_len_known = 1'b1;
      end
    end
    n = (p_count == 9'h1FF) ? p_count : p_count + 9'd1;
    if (!(p_len_known && n >= p_target)) begin
      if (p_count >= 9'd2) p_sum = p_sum + b;
      p_prev  = b;
      p_count = n;
      return 1'b0;
    end
    if (n < 9'd4 || nibble_swap(p_b1) != p_head) begin
      st = ST_FORMAT;
    end else if (n == 9'd4) begin
      st = ((p_b2 == ACK_A || p_b2 == ACK_B) && b == TAIL_MARK) ? ST_ACCEPT : ST_FORMAT;
    end else begin
      // p_sum still holds the checksum byte itself
      chk = p_sum - p_prev;
      st  = (chk == p_prev && b == TAIL_MARK) ? ST_ACCEPT : ST_CHECK;
    end
    done.command_id    = p_head;
    done.packet_length = n;
    done.status        = st;
    p_open      = 1'b0;
    p_count     = '0;
    p_target    = '0;
    p_len_known = 1'b0;
    p_sum       = '0;
    p_prev      = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mostly well-formed packets with random content; some noise, corrupted or cut short.
  task automatic queue_packet(input bit huge, output int added);
    logic [7:0] pkt [$];
    logic [7:0] id;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] sum;
    bit         varlen;
    int         len;
    int         kept;
    int         i;
    added = 0;
    if (!huge && $urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 3)) begin
        bytes_to_send.insert(bytes_to_send.size(), 8'($urandom));
        added++;
      end
      return;
    end
    id  = huge ? ID_VARLEN : pick_id();
    b1  = (!huge && $urandom_range(99) < 10) ? 8'($urandom) : nibble_swap(id);
    len = int'(id_length(id, varlen));
    b2  = 8'($urandom);
    if (varlen) begin
      b2  = huge ? 8'($urandom_range(251, 255)) : 8'($urandom_range(0, 12));
      len = int'(b2) + 5;
    end else if (id == ID_BT && b1 == BT_SECOND) begin
      case ($urandom_range(3))
        0:       b2 = BT_NO_LEN;
        1:       b2 = 8'($urandom_range(0, 2));
        default: b2 = 8'($urandom_range(3, 20));
      endcase
      // lengths below three still close on the third byte
      if (b2 == BT_NO_LEN) len = 10;
      else if (b2 <= 8'd2) len = 3;
      else len = int'(b2) + 1;
    end else if (len == 4 && $urandom_range(99) < 80) begin
      b2 = $urandom_range(1) ? ACK_A : ACK_B;
    end
    pkt = '{id, b1, b2};
    if (len == 4) begin
      pkt.insert(pkt.size(), ($urandom_range(99) < 85) ? TAIL_MARK : 8'($urandom));
    end else if (len >= 5) begin
      sum = b2;
      for (i = 3; i <= len - 3; i++) begin
        pkt.insert(pkt.size(), 8'($urandom));
        sum = sum + pkt[i];
      end
      if (!huge && $urandom_range(99) < 10) sum = sum ^ 8'($urandom_range(1, 255));
      pkt.insert(pkt.size(), sum);
      pkt.insert(pkt.size(), (huge || $urandom_range(99) < 90) ? TAIL_MARK : 8'($urandom));
    end
    kept = pkt.size();
    if (!huge && $urandom_range(99) < 5) kept = $urandom_range(1, pkt.size() - 1);
    for (i = 0; i < kept; i++) bytes_to_send.insert(bytes_to_send.size(), pkt[i]);
    added = kept;
  endtask

  // Byte driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_fire) void'(bytes_to_send.pop_front());
      if (!rx_bus.valid || rx_fire) begin
        if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_bus.valid   <= 1'b1;
          rx_bus.rx_byte <= bytes_to_send[0];
        end else begin
          rx_bus.valid   <= 1'b0;
          rx_bus.rx_byte <= 8'($urandom);
        end
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        res_bus.ready <= 1'b0;
      end else if (long_hold_arm && !hold_done) begin
        hold_left     <= LONG_HOLD;
        hold_done     <= 1'b1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk_i) begin
    cpd_result_t want;
    cpd_result_t got_pred;
    rx_fire  = rst_ni && rx_bus.valid && rx_bus.ready;
    res_fire = rst_ni && res_bus.valid && res_bus.ready;
    if (res_fire) begin
      if (packets_due.size() == 0) begin
        report_mismatch("unexpected result, command_id", res_bus.command_id, -1);
      end else begin
        want = packets_due.pop_front();
        if (res_bus.command_id !== want.command_id)
          report_mismatch("command_id", res_bus.command_id, want.command_id);
        if (res_bus.packet_length !== want.packet_length)
          report_mismatch("packet_length", res_bus.packet_length, want.packet_length);
        if (res_bus.status !== want.status)
          report_mismatch("status", res_bus.status, want.status);
      end
    end
    if (rx_fire && deframe_byte(rx_bus.rx_byte, got_pred))
      packets_due.insert(packets_due.size(), got_pred);
    if (rst_ni) begin
      if (rx_fire || res_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct [4]  = '{0, 65, 0, 31};
    int stall_pct [4] = '{0, 0, 65, 31};
    int phase;
    int queued;
    int n;
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    res_bus.ready  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_pct[phase];
      recv_stall_pct = stall_pct[phase];
      if (phase == 0) begin
        bytes_to_send = '{
          8'h00, 8'hFF,                      // unknown ids while idle, dropped
          8'hF3, 8'h3F, ACK_A, TAIL_MARK,    // acknowledge form, accepted
          8'hF4, 8'h4F, ACK_B, 8'h00,        // acknowledge with bad tail
          8'hF6, 8'h00, ACK_A, TAIL_MARK,    // nibble check fails
          ID_BT, BT_SECOND, 8'h00,           // length byte zero, closes short
          ID_BT, BT_SECOND, 8'h02,           // length three
          ID_VARLEN, 8'h1F, 8'h00, 8'h00, TAIL_MARK,  // shortest variable packet
          8'hF2, 8'h2F, 8'h10, 8'h11, TAIL_MARK       // wrong checksum
        };
      end
      queued = 0;
      if (phase % 2 == 1) begin
        queue_packet(1'b1, n);
        queued += n;
      end
      while (queued < PHASE_BYTES) begin
        queue_packet(1'b0, n);
        queued += n;
      end
      if (phase == 0) begin
        while (bytes_to_send.size() > 200) @(posedge clk_i);
        long_hold_arm = 1'b1;
      end
      while (bytes_to_send.size() > 0) @(posedge clk_i);
      while (packets_due.size() > 0) @(negedge clk_i);
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
